// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Constants, round functions and the schedule control bundle.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  // Initial chaining value.
  localparam logic [31:0] IV_WORDS [0:4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_00_19 = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  localparam logic [6:0] LAST_ROUND   = 7'd79;
  localparam logic [6:0] FIRST_EXPAND = 7'd16;

  // Control from the sequencer to the schedule memory.
  typedef struct packed {
    logic        fill_we;
    logic [3:0]  fill_addr;
    logic [31:0] fill_word;
    logic        round_en;
    logic [6:0]  rnd;
  } sched_ctl_t;

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] v);
    return {v[1:0], v[31:2]};
  endfunction

  // Boolean function of the round plus its constant.
  function automatic logic [31:0] round_fk(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    logic [31:0] k;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_00_19;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K_20_39;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_40_59;
    end else begin
      f = b ^ c ^ d;
      k = K_60_79;
    end
    return f + k;
  endfunction

endpackage

// ===== rtl/sha1md_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// Sixteen-word schedule memory with two registered read ports. Message words
// are written during the fill; during compression the expanded word of each
// round is formed from two memory reads and a short line of recent words,
// and written back over the entry it replaces.
// ----------------------------------------------------------------------------
module sha1md_sched (
  input  logic                   clk,
  input  sha1md_pkg::sched_ctl_t ctl,
  output logic [31:0]            w
);

  logic [31:0] mem [0:15];
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic [31:0] hist [0:7];
  logic [3:0]  addr_a;
  logic [3:0]  addr_b;
  logic [31:0] w_exp;

  // Reads are issued ahead: W[t-16] (or W[t]) and W[t-14] of the
  // next round. The load cycle before round 0 fetches entry 0.
  assign addr_a = ctl.round_en ? (ctl.rnd[3:0] + 4'd1) : 4'd0;
  assign addr_b = addr_a + 4'd2;

  // W[t] = rotl1(W[t-3] ^ W[t-8] ^ W[t-14] ^ W[t-16]).
  assign w_exp = sha1md_pkg::rotl1(hist[2] ^ hist[7] ^ rd_b ^ rd_a);
  assign w     = (ctl.rnd < sha1md_pkg::FIRST_EXPAND) ? rd_a : w_exp;

  // Memory: one write port, two registered read ports. The entry written in a
  // round never matches the entries read for the following round.
  always_ff @(posedge clk) begin
    if (ctl.fill_we) begin
      mem[ctl.fill_addr] <= ctl.fill_word;
    end else if (ctl.round_en && ctl.rnd >= sha1md_pkg::FIRST_EXPAND) begin
      mem[ctl.rnd[3:0]] <= w;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Line of the eight most recent schedule words.
  always_ff @(posedge clk) begin
    if (ctl.round_en) begin
      hist[0] <= w;
      for (int i = 1; i < 8; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

endmodule

// ===== rtl/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Takes a message one byte per item, compresses each 64-byte block, pads the
// final block with the bit length and returns the five digest words.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  data_byte, byte_present, last_byte
//  out      out_valid/out_ready  digest_word, word_number, last_word
//
// Message bytes are accepted back to back while in_ready is high. Every 64th
// byte starts a compression (load, 80 rounds, chaining add), one round per
// cycle through the schedule memory. A final item adds the padding bytes and
// one or two compressions, then five result items, one per cycle while
// out_ready is high. There is no clearing pass on reset. in_ready is low
// during compression, padding and while the digest is being delivered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);

  // Sequencer states.
  localparam logic [2:0] ST_FEED  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Message phases.
  localparam logic [2:0] PH_MSG  = 3'd0;
  localparam logic [2:0] PH_MARK = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  logic [2:0]  state;
  logic [2:0]  phase;
  logic [5:0]  block_fill;
  logic [2:0]  len_idx;
  logic [63:0] message_bit_count;
  logic [6:0]  round_count;
  logic [23:0] word_acc;
  logic [2:0]  word_idx;
  logic [31:0] chain_value [0:4];
  logic [31:0] work_regs [0:4];

  logic        in_acc;
  logic        out_acc;
  logic        put_en;
  logic [7:0]  put_data;
  logic [2:0]  len_sel;
  logic [31:0] w;
  logic [31:0] t_sum;
  sha1md_pkg::sched_ctl_t sched_ctl;

  assign in_ready  = (state == ST_FEED) && (phase == PH_MSG);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);
  assign out_acc   = out_valid && out_ready;

  assign digest_word = chain_value[word_idx];
  assign word_number = word_idx;
  assign last_word   = (word_idx == LAST_INDEX);

  // Byte source: message bytes, then the marker, zero fill and bit length.
  assign len_sel = 3'd7 - len_idx;
  always_comb begin
    put_en   = 1'b0;
    put_data = 8'h00;
    if (state == ST_FEED) begin
      unique case (phase)
        PH_MSG: begin
          put_en   = in_acc && byte_present;
          put_data = data_byte;
        end
        PH_MARK: begin
          put_en   = 1'b1;
          put_data = 8'h80;
        end
        PH_ZERO: begin
          put_en   = (block_fill != LEN_START);
        end
        PH_LEN: begin
          put_en   = 1'b1;
          put_data = message_bit_count[{len_sel, 3'b000} +: 8];
        end
        default: begin
          put_en   = 1'b0;
        end
      endcase
    end
  end

  // Schedule memory control: a full word is written on every fourth byte.
  always_comb begin
    sched_ctl.fill_we   = put_en && (block_fill[1:0] == 2'd3);
    sched_ctl.fill_addr = block_fill[5:2];
    sched_ctl.fill_word = {word_acc, put_data};
    sched_ctl.round_en  = (state == ST_ROUND);
    sched_ctl.rnd       = round_count;
  end

  sha1md_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w   (w)
  );

  // Round sum.
  assign t_sum = sha1md_pkg::rotl5(work_regs[0])
               + sha1md_pkg::round_fk(round_count, work_regs[1], work_regs[2], work_regs[3])
               + work_regs[4] + w;

  // Byte packing register.
  always_ff @(posedge clk) begin
    if (put_en) begin
      word_acc <= {word_acc[15:0], put_data};
    end
  end

  // Sequencer, counters, working variables and chaining value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_FEED;
      phase             <= PH_MSG;
      block_fill        <= 6'd0;
      len_idx           <= 3'd0;
      message_bit_count <= 64'd0;
      round_count       <= 7'd0;
      word_idx          <= 3'd0;
      for (int i = 0; i < 5; i++) begin
        chain_value[i] <= sha1md_pkg::IV_WORDS[i];
        work_regs[i]   <= 32'd0;
      end
    end else begin
      unique case (state)
        ST_FEED: begin
          if (in_acc && byte_present) begin
            message_bit_count <= message_bit_count + 64'd8;
          end
          if (put_en) begin
            block_fill <= block_fill + 6'd1;
            if (block_fill == BLOCK_LAST) begin
              state <= ST_LOAD;
            end
          end
          unique case (phase)
            PH_MSG: begin
              if (in_acc && last_byte) begin
                phase <= PH_MARK;
              end
            end
            PH_MARK: begin
              phase <= PH_ZERO;
            end
            PH_ZERO: begin
              if (block_fill == LEN_START) begin
                phase <= PH_LEN;
              end
            end
            PH_LEN: begin
              len_idx <= len_idx + 3'd1;
              if (len_idx == 3'd7) begin
                phase <= PH_DONE;
              end
            end
            default: begin
              phase <= phase;
            end
          endcase
        end
        ST_LOAD: begin
          round_count <= 7'd0;
          for (int i = 0; i < 5; i++) begin
            work_regs[i] <= chain_value[i];
          end
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          work_regs[0] <= t_sum;
          work_regs[1] <= work_regs[0];
          work_regs[2] <= sha1md_pkg::rotl30(work_regs[1]);
          work_regs[3] <= work_regs[2];
          work_regs[4] <= work_regs[3];
          round_count  <= round_count + 7'd1;
          if (round_count == sha1md_pkg::LAST_ROUND) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 5; i++) begin
            chain_value[i] <= chain_value[i] + work_regs[i];
          end
          state <= (phase == PH_DONE) ? ST_OUT : ST_FEED;
        end
        ST_OUT: begin
          if (out_acc) begin
            word_idx <= word_idx + 3'd1;
            if (word_idx == LAST_INDEX) begin
              // Digest delivered: back to the state of a fresh message.
              state             <= ST_FEED;
              phase             <= PH_MSG;
              block_fill        <= 6'd0;
              len_idx           <= 3'd0;
              message_bit_count <= 64'd0;
              word_idx          <= 3'd0;
              for (int i = 0; i < 5; i++) begin
                chain_value[i] <= sha1md_pkg::IV_WORDS[i];
              end
            end
          end
        end
        default: begin
          state <= ST_FEED;
        end
      endcase
    end
  end

  // Input and output sides are never open together.
  `ASSERT_SAME(a_no_overlap, 1'b1, !(in_ready && out_valid), "in_ready with out_valid")
  // The round counter stays inside the compression.
  `ASSERT_SAME(a_round_range, state == ST_ROUND, round_count <= sha1md_pkg::LAST_ROUND,
               "round counter out of range")
  // The last round is always followed by the chaining add.
  `ASSERT_NEXT(a_round_to_add, (state == ST_ROUND) && (round_count == sha1md_pkg::LAST_ROUND),
               state == ST_ADD, "last round not followed by the add")
  // Delivery of the final word leaves the block ready for a new message.
  `ASSERT_NEXT(a_fresh_message, out_acc && last_word,
               in_ready && (block_fill == 6'd0) && (message_bit_count == 64'd0),
               "block not cleared after the digest")

endmodule
